### hdl/ges_pkg.sv
// Shared types, codes and constants of the gyro event smoother.
// Used by ges_front, ges_queue, ges_back and gyro_event_smoother_top.
`timescale 1ns / 1ps
package ges_pkg;

   // Input action codes.
   localparam logic [2:0] ACT_SAMPLE = 3'd0;
   localparam logic [2:0] ACT_SEED   = 3'd1;
   localparam logic [2:0] ACT_SEC    = 3'd2;
   localparam logic [2:0] ACT_NSEC   = 3'd3;
   localparam logic [2:0] ACT_REPORT = 3'd4;

   // Axis codes; AXIS_NONE marks an event that is not a gyro axis.
   localparam logic [1:0] AXIS_X    = 2'd0;
   localparam logic [1:0] AXIS_Y    = 2'd1;
   localparam logic [1:0] AXIS_Z    = 2'd2;
   localparam logic [1:0] AXIS_NONE = 2'd3;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE  = 1'd1;
   localparam int unsigned CSR_DATA_W = 63;

   // Field widths.
   localparam int unsigned AVG_W   = 49;
   localparam int unsigned TIME_W  = 63;
   localparam int unsigned RATE_W  = 32;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned OPND_W  = 64;

   // Filter weights: 0.2 * 2^16 * 2^16 for the new sample, 0.8 * 2^16 for the old.
   localparam logic [29:0] NEW_WEIGHT = 30'd858980352;
   localparam logic [16:0] OLD_WEIGHT = 17'd52429;
   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
   // pi / (180 * 16.4) rad/s per count in units of 2^-24.
   localparam logic [15:0] RATE_SCALE = 16'd17855;

   // Queue depth between the front and back parts.
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Operations the back part executes.
   typedef enum logic [2:0] {
      OP_SAMPLE,
      OP_SEED,
      OP_SEC,
      OP_NSEC,
      OP_REPORT
   } op_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      op_type             op;
      logic [1:0]         axis;
      logic [OPND_W-1:0]  operand;
   } entry_type;

   // Scales a Q33.16 average to a saturated Q7.24 rate, optionally negated.
   function automatic logic [RATE_W-1:0] rate_of(input logic [AVG_W-1:0] avg,
                                                  input logic negate);
      logic signed [63:0] prod;
      logic signed [63:0] shifted;
      prod = 64'($signed(avg)) * $signed({48'd0, RATE_SCALE});
      if (negate) begin
         prod = -prod;
      end
      shifted = prod >>> 16;
      if (shifted > 64'sd2147483647) begin
         rate_of = 32'h7FFF_FFFF;
      end else if (shifted < -64'sd2147483648) begin
         rate_of = 32'h8000_0000;
      end else begin
         rate_of = shifted[RATE_W-1:0];
      end
   endfunction

endpackage

### hdl/gyro_event_smoother_top.sv
// Top level of the gyro event smoother: front part, request queue and back part.
// Depends on ges_pkg, ges_front, ges_queue and ges_back.
//
// Usage:
// Requests arrive on the req_ channel (valid/ready): an action, an axis, a
// signed value and the event's arrival time. Axis samples blend into a
// per-axis moving average, seeds load it, sync events build an absolute
// timestamp, and a sync report yields one response on the rsp_ channel with
// the three angular rates (Q7.24 rad/s) and the stamp, when enabled and at or
// past the ignore bound. Other requests produce no response.
// The csr_ port writes the enable and ignore-bound registers; write only while
// the block is idle.
// Throughput is one request per cycle while the receiver does not stall;
// each average is updated by one multiply-add in the back part. A request
// passes through the front stage register and the queue before the back
// part loads the result register with its response.
// When the receiver stalls, the result register holds its response and the
// four-entry queue absorbs requests; requests keep being accepted until the
// queue and the front stage fill. Synchronous reset clears the averages,
// timestamps, configuration and all valid flags; no response is pending.
`timescale 1ns / 1ps
module gyro_event_smoother_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ges_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ges_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_action,
   input  logic [1:0]                         req_axis,
   input  logic signed [31:0]                 req_value,
   input  logic [62:0]                        req_event_time_ns,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_rate_x,
   output logic signed [31:0]                 rsp_rate_y,
   output logic signed [31:0]                 rsp_rate_z,
   output logic [62:0]                        rsp_stamp_ns
);
   import ges_pkg::*;

   logic       push_valid, push_ready;
   entry_type  push_entry;
   logic       pop_valid, pop_ready;
   entry_type  pop_entry;

   // Front part: accept and classify requests.
   ges_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_axis          (req_axis),
      .req_value         (req_value),
      .req_event_time_ns (req_event_time_ns),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_entry        (push_entry)
   );

   // Queue between the two parts.
   ges_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Back part: execute requests and deliver responses.
   ges_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_entry    (pop_entry),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_rate_x   (rsp_rate_x),
      .rsp_rate_y   (rsp_rate_y),
      .rsp_rate_z   (rsp_rate_z),
      .rsp_stamp_ns (rsp_stamp_ns)
   );

endmodule

### hdl/ges_front.sv
// Front part of the gyro event smoother: accepts requests, drops ignored
// ones, and precomputes each operand. Depends on ges_pkg.
`timescale 1ns / 1ps
module ges_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_action,
   input  logic [1:0]                    req_axis,
   input  logic signed [31:0]            req_value,
   input  logic [62:0]                   req_event_time_ns,
   output logic                          push_valid,
   input  logic                          push_ready,
   output ges_pkg::entry_type            push_entry
);
   import ges_pkg::*;

   logic              stg_valid_ff, stg_valid_in;
   entry_type         stg_entry_ff, stg_entry_in;
   logic              keep;
   logic signed [63:0] value64;
   logic [29:0]       factor;
   logic [63:0]       product;

   // The stage frees up whenever its request moves into the queue.
   assign req_ready = !stg_valid_ff || push_ready;

   // Single multiplier: sample weight or nanoseconds per second.
   assign value64 = 64'(req_value);
   assign factor  = (req_action == ACT_SEC) ? NS_PER_SEC : NEW_WEIGHT;
   assign product = value64 * $signed({34'd0, factor});

   // Classify the request and build its operand.
   always_comb begin
      keep         = 1'b1;
      stg_entry_in = '0;
      stg_entry_in.axis = req_axis;
      case (req_action)
         ACT_SAMPLE: begin
            keep = (req_axis != AXIS_NONE);
            stg_entry_in.op      = OP_SAMPLE;
            stg_entry_in.operand = product;
         end
         ACT_SEED: begin
            keep = (req_axis != AXIS_NONE);
            stg_entry_in.op      = OP_SEED;
            stg_entry_in.operand = value64 <<< 16;
         end
         ACT_SEC: begin
            stg_entry_in.op      = OP_SEC;
            stg_entry_in.operand = product;
         end
         ACT_NSEC: begin
            stg_entry_in.op      = OP_NSEC;
            stg_entry_in.operand = value64;
         end
         ACT_REPORT: begin
            stg_entry_in.op      = OP_REPORT;
            stg_entry_in.operand = {1'b0, req_event_time_ns};
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign stg_valid_in = req_ready ? (req_valid && keep) : stg_valid_ff;

   // Stage register between the ports and the queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_entry_ff <= stg_entry_in;
      end
   end

   assign push_valid = stg_valid_ff;
   assign push_entry = stg_entry_ff;

endmodule

### hdl/ges_queue.sv
// Short first-in first-out queue of classified requests between the front
// and back parts. Depends on ges_pkg.
`timescale 1ns / 1ps
module ges_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  ges_pkg::entry_type  push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output ges_pkg::entry_type  pop_entry
);
   import ges_pkg::*;

   entry_type            slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? Q_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? Q_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = Q_CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = Q_CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/ges_back.sv
// Back part of the gyro event smoother: runs the averages, timestamp state
// and configuration, and holds the result register. Depends on ges_pkg.
`timescale 1ns / 1ps
module ges_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [ges_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ges_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  ges_pkg::entry_type                 pop_entry,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [31:0]                 rsp_rate_x,
   output logic signed [31:0]                 rsp_rate_y,
   output logic signed [31:0]                 rsp_rate_z,
   output logic [62:0]                        rsp_stamp_ns
);
   import ges_pkg::*;

   logic                 enabled_ff;
   logic [TIME_W-1:0]    ignore_ff;
   logic [AVG_W-1:0]     avg_x_ff, avg_x_in;
   logic [AVG_W-1:0]     avg_y_ff, avg_y_in;
   logic [AVG_W-1:0]     avg_z_ff, avg_z_in;
   logic [63:0]          sec_part_ff, sec_part_in;
   logic [63:0]          stamp_ff, stamp_in;
   logic                 abs_mode_ff, abs_mode_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]    rate_x_ff, rate_y_ff, rate_z_ff;
   logic [TIME_W-1:0]    rsp_stamp_ff;

   logic [AVG_W-1:0]     avg_sel, avg_upd;
   logic signed [63:0]   blend;
   logic [63:0]          report_stamp;
   logic                 is_report, emit, out_free, fire, do_pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         ignore_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLED: enabled_ff <= csr_wdata[0];
            CSR_IGNORE:  ignore_ff  <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // Report decision: stamp selection and the signed ignore-bound compare.
   assign is_report    = (pop_entry.op == OP_REPORT);
   assign report_stamp = abs_mode_ff ? stamp_ff : pop_entry.operand;
   assign emit = enabled_ff && ($signed(report_stamp) >= $signed({1'b0, ignore_ff}));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = !(is_report && emit) || out_free;
   assign do_pop    = pop_valid && pop_ready;
   assign fire      = do_pop && is_report && emit;

   // Filter update for the addressed axis.
   always_comb begin
      case (pop_entry.axis)
         AXIS_X:  avg_sel = avg_x_ff;
         AXIS_Y:  avg_sel = avg_y_ff;
         default: avg_sel = avg_z_ff;
      endcase
   end

   assign blend   = $signed(pop_entry.operand)
                  + 64'($signed(avg_sel)) * $signed({47'd0, OLD_WEIGHT});
   assign avg_upd = {blend[63], blend[63:16]};

   // Next state of the averages and timestamp registers.
   always_comb begin
      avg_x_in    = avg_x_ff;
      avg_y_in    = avg_y_ff;
      avg_z_in    = avg_z_ff;
      sec_part_in = sec_part_ff;
      stamp_in    = stamp_ff;
      abs_mode_in = abs_mode_ff;
      if (do_pop) begin
         case (pop_entry.op)
            OP_SAMPLE: begin
               case (pop_entry.axis)
                  AXIS_X:  avg_x_in = avg_upd;
                  AXIS_Y:  avg_y_in = avg_upd;
                  default: avg_z_in = avg_upd;
               endcase
            end
            // A seed loads the shifted value straight into the addressed average.
            OP_SEED: begin
               case (pop_entry.axis)
                  AXIS_X:  avg_x_in = pop_entry.operand[AVG_W-1:0];
                  AXIS_Y:  avg_y_in = pop_entry.operand[AVG_W-1:0];
                  default: avg_z_in = pop_entry.operand[AVG_W-1:0];
               endcase
            end
            OP_SEC: begin
               abs_mode_in = 1'b1;
               sec_part_in = pop_entry.operand;
            end
            OP_NSEC: begin
               abs_mode_in = 1'b1;
               stamp_in    = sec_part_ff + pop_entry.operand;
            end
            OP_REPORT: begin
               stamp_in = report_stamp;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_x_ff    <= '0;
         avg_y_ff    <= '0;
         avg_z_ff    <= '0;
         sec_part_ff <= '0;
         stamp_ff    <= '0;
         abs_mode_ff <= 1'b0;
      end else begin
         avg_x_ff    <= avg_x_in;
         avg_y_ff    <= avg_y_in;
         avg_z_ff    <= avg_z_in;
         sec_part_ff <= sec_part_in;
         stamp_ff    <= stamp_in;
         abs_mode_ff <= abs_mode_in;
      end
   end

   // Result register: loads a report when the slot is empty or being drained.
   assign rsp_valid_in = out_free ? fire : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rate_x_ff    <= rate_of(avg_x_ff, 1'b1);
         rate_y_ff    <= rate_of(avg_y_ff, 1'b0);
         rate_z_ff    <= rate_of(avg_z_ff, 1'b1);
         rsp_stamp_ff <= report_stamp[TIME_W-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rate_x   = rate_x_ff;
   assign rsp_rate_y   = rate_y_ff;
   assign rsp_rate_z   = rate_z_ff;
   assign rsp_stamp_ns = rsp_stamp_ff;

endmodule

### tb/smoother_book_pkg.sv
// Scoreboard for the gyro event smoother: an independent predictor of the filter,
// the timestamp logic and the rate scaling, plus the queue of expected reports.
// Depends on ges_pkg for the action, axis and register codes and the field widths.
`timescale 1ns / 1ps
package smoother_book_pkg;
   import ges_pkg::*;

   // Filter and scaling constants in the block's fixed-point formats.
   localparam logic signed [63:0] FRESH_WEIGHT  = 64'sd858980352;
   localparam logic signed [63:0] KEEP_WEIGHT   = 64'sd52429;
   localparam logic signed [63:0] RAD_PER_COUNT = 64'sd17855;
   localparam logic signed [63:0] NS_IN_SECOND  = 64'sd1000000000;
   localparam logic signed [63:0] RATE_MAX      = 64'sd2147483647;
   localparam logic signed [63:0] RATE_MIN      = -64'sd2147483648;

   // One rate report as it appears on the response channel.
   typedef struct {
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
      logic [TIME_W-1:0]  stamp_ns;
   } rate_report;

   class rate_report_book;
      logic [AVG_W-1:0]   avg_q [3];
      logic signed [63:0] seconds_ns;
      logic signed [63:0] stamp;
      bit                 absolute_mode;
      bit                 enabled;
      logic [TIME_W-1:0]  ignore_bound;
      rate_report         expected_reports [$];
      int                 mismatches;

      function new();
         foreach (avg_q[i]) begin
            avg_q[i] = '0;
         end
         seconds_ns    = '0;
         stamp         = '0;
         absolute_mode = 1'b0;
         enabled       = 1'b0;
         ignore_bound  = '0;
         mismatches    = 0;
      endfunction

      // Mirrors a register write; bits above a register's width are dropped.
      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_ENABLED) begin
            enabled = data[0];
         end else if (index == CSR_IGNORE) begin
            ignore_bound = data[TIME_W-1:0];
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      // Sign-extends a Q33.16 average to 64 bits.
      function logic signed [63:0] widen_avg(logic [AVG_W-1:0] a);
         return $signed({{(64 - AVG_W){a[AVG_W-1]}}, a});
      endfunction

      // Average times the rate scale, shifted down by 16 and clamped to 32 bits.
      function logic signed [31:0] scaled_rate(logic [AVG_W-1:0] a, bit negate);
         logic signed [63:0] prod;
         logic signed [63:0] shifted;
         prod = widen_avg(a) * RAD_PER_COUNT;
         if (negate) begin
            prod = -prod;
         end
         shifted = prod >>> 16;
         if (shifted > RATE_MAX) begin
            return 32'sh7FFF_FFFF;
         end
         if (shifted < RATE_MIN) begin
            return 32'sh8000_0000;
         end
         return shifted[31:0];
      endfunction

      // Applies one accepted request and queues the report it produces, if any.
      function void absorb_event(logic [2:0] action, logic [1:0] axis,
                                 logic signed [31:0] value, logic [TIME_W-1:0] event_time);
         logic signed [63:0] v;
         logic signed [63:0] sum;
         rate_report         r;
         v = value;
         case (action)
            ACT_SAMPLE: begin
               if (axis != AXIS_NONE) begin
                  sum = v * FRESH_WEIGHT + widen_avg(avg_q[axis]) * KEEP_WEIGHT;
                  sum = sum >>> 16;
                  avg_q[axis] = sum[AVG_W-1:0];
               end
            end
            ACT_SEED: begin
               if (axis != AXIS_NONE) begin
                  sum = v <<< 16;
                  avg_q[axis] = sum[AVG_W-1:0];
               end
            end
            ACT_SEC: begin
               absolute_mode = 1'b1;
               seconds_ns    = v * NS_IN_SECOND;
            end
            ACT_NSEC: begin
               absolute_mode = 1'b1;
               stamp         = seconds_ns + v;
            end
            ACT_REPORT: begin
               // The event's own time counts only until a sync event was seen.
               if (!absolute_mode) begin
                  stamp = {1'b0, event_time};
               end
               // Signed comparison: a negative stamp never reaches the bound.
               if (enabled && stamp >= $signed({1'b0, ignore_bound})) begin
                  r.rate_x   = scaled_rate(avg_q[AXIS_X], 1'b1);
                  r.rate_y   = scaled_rate(avg_q[AXIS_Y], 1'b0);
                  r.rate_z   = scaled_rate(avg_q[AXIS_Z], 1'b1);
                  r.stamp_ns = stamp[TIME_W-1:0];
                  expected_reports.push_back(r);
               end
            end
            default: begin
            end
         endcase
      endfunction

      // Compares an accepted report with the oldest expected one.
      function void check_report(rate_report got);
         rate_report want;
         if (expected_reports.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected rate report: x=%0d y=%0d z=%0d stamp=%0d",
                        got.rate_x, got.rate_y, got.rate_z, got.stamp_ns);
            end
            mismatches++;
            return;
         end
         want = expected_reports.pop_front();
         if (want.rate_x !== got.rate_x || want.rate_y !== got.rate_y ||
             want.rate_z !== got.rate_z || want.stamp_ns !== got.stamp_ns) begin
            if (mismatches < 10) begin
               $display("rate report mismatch: expected x=%0d y=%0d z=%0d stamp=%0d",
                        want.rate_x, want.rate_y, want.rate_z, want.stamp_ns);
               $display("                      actual   x=%0d y=%0d z=%0d stamp=%0d",
                        got.rate_x, got.rate_y, got.rate_z, got.stamp_ns);
            end
            mismatches++;
         end
      endfunction
   endclass

endpackage

### tb/tb_top.sv
// Testbench top for gyro_event_smoother_top: directed and random request streams,
// random stalls on both channels, checked against the scoreboard in smoother_book_pkg.
// Depends on ges_pkg, smoother_book_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_top;
   import ges_pkg::*;
   import smoother_book_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [2:0]        ACT_OTHER = 3'd5;
   localparam logic [TIME_W-1:0] TIME_MAX  = '1;
   localparam logic [31:0]       VALUE_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0]       VALUE_MIN = 32'h8000_0000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_action = '0;
   logic [1:0]            req_axis = '0;
   logic signed [31:0]    req_value = '0;
   logic [TIME_W-1:0]     req_event_time_ns = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [31:0]    rsp_rate_x;
   logic signed [31:0]    rsp_rate_y;
   logic signed [31:0]    rsp_rate_z;
   logic [TIME_W-1:0]     rsp_stamp_ns;

   logic calm = 1'b0;
   logic want_hold = 1'b0;
   bit   hold_used = 1'b0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   rate_report_book book = new();

   gyro_event_smoother_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_axis          (req_axis),
      .req_value         (req_value),
      .req_event_time_ns (req_event_time_ns),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rate_x        (rsp_rate_x),
      .rsp_rate_y        (rsp_rate_y),
      .rsp_rate_z        (rsp_rate_z),
      .rsp_stamp_ns      (rsp_stamp_ns)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, one long hold-off on request, none while calm.
   always @(posedge clock) begin : drive_receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (want_hold && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 23);
      end
   end

   // Both handshakes feed the scoreboard; the quiet counter feeds the watchdog.
   always @(posedge clock) begin : watch_ports
      rate_report seen;
      if (!reset) begin
         if (req_valid && req_ready) begin
            book.absorb_event(req_action, req_axis, req_value, req_event_time_ns);
         end
         if (rsp_valid && rsp_ready) begin
            seen.rate_x   = rsp_rate_x;
            seen.rate_y   = rsp_rate_y;
            seen.rate_z   = rsp_rate_z;
            seen.stamp_ns = rsp_stamp_ns;
            book.check_report(seen);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
      end
      $display("tb_top failed");
      $finish;
   end

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 5))
         0: return VALUE_MAX;
         1: return VALUE_MIN;
         2: return 32'($urandom_range(0, 200)) - 32'd100;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return '0;
         1: return TIME_MAX;
         2: return w[TIME_W-1:0] >> $urandom_range(1, 62);
         default: return w[TIME_W-1:0];
      endcase
   endfunction

   // Seconds values that keep absolute stamps near zero as well as far out.
   function automatic logic [31:0] rand_seconds();
      case ($urandom_range(0, 3))
         0: return 32'($urandom_range(0, 9));
         1: return 32'(-int'($urandom_range(1, 9)));
         2: return 32'($urandom_range(0, 2000000000));
         default: return $urandom;
      endcase
   endfunction

   // Offers one request, with random idle cycles ahead of it, and waits for acceptance.
   task automatic send_req(input logic [2:0] act, input logic [1:0] ax,
                           input logic signed [31:0] val, input logic [TIME_W-1:0] t);
      while (!calm && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_axis          <= ax;
      req_value         <= val;
      req_event_time_ns <= t;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Waits until the block has drained, then writes both registers.
   task automatic set_config(input logic [CSR_DATA_W-1:0] en_data,
                             input logic [CSR_DATA_W-1:0] bound);
      req_valid <= 1'b0;
      while (book.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_ENABLED;
      csr_wdata <= en_data;
      @(posedge clock);
      book.write_register(CSR_ENABLED, en_data);
      csr_index <= CSR_IGNORE;
      csr_wdata <= bound;
      @(posedge clock);
      book.write_register(CSR_IGNORE, bound);
      csr_we <= 1'b0;
   endtask

   // Mostly enabled, with an ignore bound of random magnitude.
   task automatic random_config();
      logic [CSR_DATA_W-1:0] en_data;
      en_data    = rand_time();
      en_data[0] = ($urandom_range(0, 5) != 0);
      set_config(en_data, rand_time());
   endtask

   // Random traffic: mostly sample bursts closed by a report (with a sync pair in
   // absolute mode), the rest single requests with any axis and any action but sync outside absolute mode.
   task automatic run_chunk(input int count, input bit with_sync);
      int         sent;
      int         burst;
      logic [2:0] act;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            burst = $urandom_range(1, 4);
            repeat (burst) begin
               act = ($urandom_range(0, 9) == 0) ? ACT_SEED : ACT_SAMPLE;
               send_req(act, 2'($urandom_range(0, 2)), rand_value(), rand_time());
            end
            if (with_sync) begin
               send_req(ACT_SEC, 2'($urandom_range(0, 3)), rand_seconds(), rand_time());
               send_req(ACT_NSEC, 2'($urandom_range(0, 3)), rand_value(), rand_time());
            end
            send_req(ACT_REPORT, 2'($urandom_range(0, 3)), rand_value(), rand_time());
            sent = sent + burst + (with_sync ? 3 : 1);
         end else begin
            act = 3'($urandom_range(0, 7));
            if (!with_sync && (act == ACT_SEC || act == ACT_NSEC)) begin
               act = ACT_OTHER;
            end
            send_req(act, 2'($urandom_range(0, 3)), rand_value(), rand_time());
            if (act <= ACT_REPORT) begin
               sent++;
            end
         end
      end
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Disabled after reset: reports are dropped, ignored actions and axis leave no trace.
      send_req(ACT_REPORT, AXIS_X, 32'sd0, TIME_MAX);
      send_req(ACT_SAMPLE, AXIS_X, VALUE_MAX, '0);
      send_req(ACT_OTHER, AXIS_Y, VALUE_MIN, TIME_MAX);
      send_req(ACT_SEED, AXIS_NONE, VALUE_MIN, '0);
      send_req(ACT_SAMPLE, AXIS_NONE, VALUE_MAX, '0);

      // Enabled with every data bit set; seeds and samples at the value extremes.
      set_config('1, '0);
      send_req(ACT_REPORT, AXIS_X, 32'sd0, '0);
      send_req(ACT_SEED, AXIS_X, VALUE_MAX, '0);
      send_req(ACT_SEED, AXIS_Y, VALUE_MIN, '0);
      send_req(ACT_SEED, AXIS_Z, VALUE_MAX, '0);
      send_req(ACT_REPORT, AXIS_NONE, VALUE_MIN, rand_time());
      send_req(ACT_SAMPLE, AXIS_Y, VALUE_MAX, '0);
      send_req(ACT_SAMPLE, AXIS_Z, VALUE_MIN, '0);
      send_req(ACT_SAMPLE, AXIS_X, -32'sd1, '0);
      send_req(ACT_REPORT, AXIS_X, 32'sd0, TIME_MAX);

      // Largest ignore bound: only a stamp at the very top gets through.
      set_config(63'd1, TIME_MAX);
      send_req(ACT_REPORT, AXIS_X, 32'sd0, TIME_MAX - 1'b1);
      send_req(ACT_REPORT, AXIS_X, 32'sd0, TIME_MAX);

      // Random traffic while stamps still come from the event time.
      set_config(63'd1, '0);
      run_chunk(100, 1'b0);
      set_config(63'd1, rand_time());
      run_chunk(100, 1'b0);
      calm <= 1'b1;
      set_config(63'd1, rand_time() >> 20);
      run_chunk(100, 1'b0);
      calm <= 1'b0;
      set_config(rand_time() & ~63'd1, '0);
      run_chunk(100, 1'b0);
      set_config(63'd1, TIME_MAX);
      run_chunk(100, 1'b0);

      // Absolute time: largest, negative and zero stamps; the event time no longer counts.
      set_config(63'd1, '0);
      send_req(ACT_SEC, AXIS_X, VALUE_MAX, '0);
      send_req(ACT_NSEC, AXIS_X, VALUE_MAX, '0);
      send_req(ACT_REPORT, AXIS_X, 32'sd0, '0);
      send_req(ACT_SEC, AXIS_Y, VALUE_MIN, TIME_MAX);
      send_req(ACT_NSEC, AXIS_Y, VALUE_MIN, TIME_MAX);
      send_req(ACT_REPORT, AXIS_Y, 32'sd0, TIME_MAX);
      send_req(ACT_SEC, AXIS_Z, 32'sd0, '0);
      send_req(ACT_NSEC, AXIS_Z, 32'sd0, '0);
      send_req(ACT_REPORT, AXIS_Z, 32'sd0, TIME_MAX);
      send_req(ACT_NSEC, AXIS_NONE, -32'sd1, '0);
      send_req(ACT_REPORT, AXIS_NONE, 32'sd0, TIME_MAX);

      // Random traffic in absolute mode; the first chunk runs into a long receiver hold-off.
      for (int c = 0; c < 10; c++) begin
         if (c == 0) begin
            want_hold <= 1'b1;
         end else begin
            random_config();
         end
         run_chunk(150, 1'b1);
      end

      // Drain and report.
      req_valid <= 1'b0;
      while (book.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

### gyro_event_smoother_top.f
hdl/ges_pkg.sv
hdl/ges_front.sv
hdl/ges_queue.sv
hdl/ges_back.sv
hdl/gyro_event_smoother_top.sv
tb/smoother_book_pkg.sv
tb/tb_top.sv
